### rtl/rbi_pkg.sv
package rbi_pkg;

   // Number format and raster geometry
   localparam int FRAC_BITS   = 16;
   localparam int MAX_COLS    = 256;
   localparam int MAX_ROWS    = 256;
   localparam int VAL_W       = 32;
   localparam int COORD_W     = 32;
   localparam int IDX_W       = 16;
   localparam int STORE_DEPTH = 1 << IDX_W;
   localparam int DIM_W       = 9;
   localparam int AX_W        = (MAX_COLS > MAX_ROWS) ? $clog2(MAX_COLS) : $clog2(MAX_ROWS);
   localparam int WIDTH_W     = 31;

   // Divider widths: |point - origin| needs one bit more than a coordinate
   localparam int DIFF_W    = COORD_W + 1;
   localparam int NUM_W     = DIFF_W + FRAC_BITS;
   localparam int DVS_W     = 32;
   localparam int DIV_STEPS = NUM_W;
   localparam int QF_W      = NUM_W + 1;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_CELL_WIDTH  = 3'd2,
      CSR_CELL_HEIGHT = 3'd3,
      CSR_COLUMNS     = 3'd4,
      CSR_ROWS        = 3'd5,
      CSR_CLAMP_MIN   = 3'd6,
      CSR_CLAMP_MAX   = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [WIDTH_W-1:0] cell_width;
      logic [DVS_W-1:0]   height_mag;
      logic               height_neg;
      logic [DIM_W-1:0]   ncols;
      logic [DIM_W-1:0]   nrows;
      logic [VAL_W-1:0]   clamp_min;
      logic [VAL_W-1:0]   clamp_max;
   } cfg_type;

   // Classified item as it leaves the front part
   typedef struct packed {
      cmd_type          cmd;
      logic [NUM_W-1:0] num_x;
      logic             neg_x;
      logic [NUM_W-1:0] num_y;
      logic             neg_y;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
   } item_type;

endpackage

### rtl/rbi_front.sv
module rbi_front (
   input  logic                      clock,
   input  logic                      reset,
   input  rbi_pkg::cfg_type          cfg,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_command,
   input  logic [31:0]               req_point_x,
   input  logic [31:0]               req_point_y,
   input  logic [15:0]               req_cell_index,
   input  logic [31:0]               req_cell_value,
   output rbi_pkg::item_type         head,
   output logic                      head_valid,
   input  logic                      head_take
);

   localparam int DW = rbi_pkg::DIFF_W;

   logic        front_valid_ff;
   logic        cmd_ff;
   logic [31:0] px_ff, py_ff, val_ff;
   logic [15:0] idx_ff;

   rbi_pkg::item_type q_mem_ff [2];
   logic              q_wr_ff, q_rd_ff;
   logic [1:0]        q_count_ff;

   logic              accept, q_full, q_push, q_pop;
   logic [DW-1:0]     dx_in, dy_in, mx_in, my_in;
   rbi_pkg::item_type item_in;

   assign q_full   = (q_count_ff == 2'd2);
   assign q_push   = front_valid_ff && !q_full;
   assign q_pop    = head_take && (q_count_ff != 2'd0);
   assign req_full = front_valid_ff && q_full;
   assign accept   = req_push && !req_full;

   // Offset from origin, split into magnitude and quotient sign
   always_comb begin
      dx_in = {px_ff[31], px_ff} - {cfg.origin_x[31], cfg.origin_x};
      dy_in = {py_ff[31], py_ff} - {cfg.origin_y[31], cfg.origin_y};
      mx_in = dx_in[DW-1] ? (~dx_in + DW'(1)) : dx_in;
      my_in = dy_in[DW-1] ? (~dy_in + DW'(1)) : dy_in;
      item_in.cmd   = rbi_pkg::cmd_type'(cmd_ff);
      item_in.num_x = {mx_in, {rbi_pkg::FRAC_BITS{1'b0}}};
      item_in.neg_x = dx_in[DW-1];
      item_in.num_y = {my_in, {rbi_pkg::FRAC_BITS{1'b0}}};
      item_in.neg_y = dy_in[DW-1] ^ cfg.height_neg;
      item_in.index = idx_ff;
      item_in.value = val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
         q_wr_ff        <= 1'b0;
         q_rd_ff        <= 1'b0;
         q_count_ff     <= 2'd0;
      end else begin
         if (accept) begin
            front_valid_ff <= 1'b1;
         end else if (q_push) begin
            front_valid_ff <= 1'b0;
         end
         if (q_push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (q_pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
         q_count_ff <= q_count_ff + 2'(q_push) - 2'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         px_ff  <= req_point_x;
         py_ff  <= req_point_y;
         idx_ff <= req_cell_index;
         val_ff <= req_cell_value;
      end
      if (q_push) begin
         q_mem_ff[q_wr_ff] <= item_in;
      end
   end

   assign head       = q_mem_ff[q_rd_ff];
   assign head_valid = (q_count_ff != 2'd0);

endmodule

### rtl/rbi_divider.sv
module rbi_divider (
   input  logic                            clock,
   input  logic                            adv,
   input  logic [rbi_pkg::NUM_W-1:0]       num,
   input  logic                            neg,
   input  logic [rbi_pkg::DVS_W-1:0]       dvs,
   output logic [rbi_pkg::QF_W-1:0]        quot
);

   localparam int NW = rbi_pkg::NUM_W;
   localparam int DW = rbi_pkg::DVS_W;
   localparam int ST = rbi_pkg::DIV_STEPS;

   logic [DW-1:0] rem_ff [ST];
   logic [NW-1:0] dq_ff  [ST];
   logic          neg_ff [ST];

   logic [DW-1:0] rem_in [ST];
   logic [NW-1:0] dq_in  [ST];
   logic          neg_in [ST];

   logic [NW:0]   qz;

   // One restoring step per stage: shift in a dividend bit, subtract if it fits
   always_comb begin
      logic [DW-1:0] rp;
      logic [NW-1:0] dp;
      logic [DW:0]   trial, diff;
      for (int s = 0; s < ST; s++) begin
         rp        = (s == 0) ? '0 : rem_ff[(s == 0) ? 0 : s - 1];
         dp        = (s == 0) ? num : dq_ff[(s == 0) ? 0 : s - 1];
         neg_in[s] = (s == 0) ? neg : neg_ff[(s == 0) ? 0 : s - 1];
         trial     = {rp, dp[NW-1]};
         diff      = trial - {1'b0, dvs};
         if (!diff[DW]) begin
            rem_in[s] = diff[DW-1:0];
            dq_in[s]  = {dp[NW-2:0], 1'b1};
         end else begin
            rem_in[s] = trial[DW-1:0];
            dq_in[s]  = {dp[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < ST; s++) begin
            rem_ff[s] <= rem_in[s];
            dq_ff[s]  <= dq_in[s];
            neg_ff[s] <= neg_in[s];
         end
      end
   end

   // Floor: a negative quotient with a remainder rounds one further down
   assign qz   = {1'b0, dq_ff[ST-1]}
               + (NW+1)'(neg_ff[ST-1] && (rem_ff[ST-1] != '0));
   assign quot = neg_ff[ST-1] ? (~qz + (NW+1)'(1)) : qz;

endmodule

### rtl/rbi_back.sv
module rbi_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rbi_pkg::cfg_type          cfg,
   input  rbi_pkg::item_type         head,
   input  logic                      head_valid,
   output logic                      head_take,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [31:0]               rsp_size_value
);

   localparam int FB   = rbi_pkg::FRAC_BITS;
   localparam int QW   = rbi_pkg::QF_W;
   localparam int AW   = rbi_pkg::AX_W;
   localparam int NDW  = rbi_pkg::DIM_W;
   localparam int IW   = rbi_pkg::IDX_W;
   localparam int VW   = rbi_pkg::VAL_W;
   localparam int ST   = rbi_pkg::DIV_STEPS;
   localparam int WT_W = FB + 1;
   localparam int P_W  = VW + WT_W + 1;
   localparam int W_W  = P_W + WT_W;
   localparam int ONE  = 1 << FB;

   typedef struct packed {
      logic          in_grid;
      logic [AW-1:0] lo;
      logic [AW-1:0] hi;
      logic [FB-1:0] frac;
   } axis_type;

   function automatic axis_type axis_pick(input logic [QW-1:0] qf, input logic [NDW-1:0] n);
      logic [QW-1:0]    lim;
      logic [QW-FB-1:0] ci, last_w;
      logic [NDW-1:0]   last, nxt;
      logic [AW-1:0]    cc;
      axis_type         a;
      last   = n - NDW'(1);
      lim    = QW'({n, {FB{1'b0}}});
      ci     = qf[QW-1:FB];
      last_w = (QW-FB)'(last);
      if (qf[QW-1]) begin
         cc = '0;
      end else if (ci > last_w) begin
         cc = last[AW-1:0];
      end else begin
         cc = ci[AW-1:0];
      end
      nxt       = NDW'(cc) + NDW'(1);
      a.in_grid = !qf[QW-1] && (qf < lim);
      a.lo      = cc;
      a.hi      = (nxt < n) ? nxt[AW-1:0] : last[AW-1:0];
      a.frac    = qf[FB-1:0];
      return a;
   endfunction

   logic adv;

   // Sideband alongside the divider stages
   logic                 dv_valid_ff [ST];
   rbi_pkg::cmd_type     dv_cmd_ff   [ST];
   logic [IW-1:0]        dv_index_ff [ST];
   logic [VW-1:0]        dv_value_ff [ST];

   logic [QW-1:0]        colq, rowq;

   logic                 s1_valid_ff;
   rbi_pkg::cmd_type     s1_cmd_ff;
   logic [IW-1:0]        s1_index_ff;
   logic [VW-1:0]        s1_value_ff;
   logic [QW-1:0]        s1_colq_ff, s1_rowq_ff;

   logic                 s2_valid_ff;
   rbi_pkg::cmd_type     s2_cmd_ff;
   logic [IW-1:0]        s2_index_ff;
   logic [VW-1:0]        s2_value_ff;
   axis_type             s2_col_ff, s2_row_ff;
   axis_type             col_in, row_in;

   logic                 s3_query_ff, s3_we_ff;
   logic [VW-1:0]        s3_value_ff;
   logic [IW-1:0]        s3_addr_ff [4];
   logic                 s3_inside_ff;
   logic [FB-1:0]        s3_fc_ff, s3_fr_ff;
   logic [AW+NDW-1:0]    base0_in, base1_in;
   logic [IW-1:0]        addr_in [4];

   logic [VW-1:0]        store0_mem [rbi_pkg::STORE_DEPTH];
   logic [VW-1:0]        store1_mem [rbi_pkg::STORE_DEPTH];
   logic [VW-1:0]        store2_mem [rbi_pkg::STORE_DEPTH];
   logic [VW-1:0]        store3_mem [rbi_pkg::STORE_DEPTH];

   logic                 s4_valid_ff, s4_inside_ff;
   logic [VW-1:0]        s4_rd_ff [4];
   logic [FB-1:0]        s4_fc_ff, s4_fr_ff;

   logic [WT_W-1:0]      wl_in;
   logic signed [P_W-1:0] p_in [4];

   logic                 s5_valid_ff, s5_inside_ff;
   logic signed [P_W-1:0] s5_p_ff [4];
   logic [VW-1:0]        s5_v00_ff;
   logic [FB-1:0]        s5_fr_ff;

   logic                 s6_valid_ff, s6_inside_ff;
   logic signed [P_W-1:0] s6_top_ff, s6_bot_ff;
   logic [VW-1:0]        s6_v00_ff;
   logic [FB-1:0]        s6_fr_ff;

   logic                 s7_valid_ff, s7_inside_ff;
   logic signed [P_W-1:0] s7_d_ff;
   logic signed [W_W-1:0] s7_tsh_ff;
   logic [VW-1:0]        s7_v00_ff;
   logic [FB-1:0]        s7_fr_ff;

   logic                 s8_valid_ff, s8_inside_ff;
   logic signed [W_W-1:0] s8_prod_ff, s8_tsh_ff;
   logic [VW-1:0]        s8_v00_ff;

   logic                 s9_valid_ff, s9_inside_ff;
   logic signed [W_W-1:0] s9_w_ff;
   logic [VW-1:0]        s9_v00_ff;

   logic [VW-1:0]        blend_in, res_in, hi_in;

   logic [VW-1:0]        out_mem_ff [2];
   logic                 out_wr_ff, out_rd_ff;
   logic [1:0]           out_count_ff;
   logic                 out_push, out_pop;

   // Advance the whole back part while the result queue has room
   assign adv       = (out_count_ff != 2'd2);
   assign head_take = adv && head_valid;

   rbi_divider u_div_col (
      .clock (clock),
      .adv   (adv),
      .num   (head.num_x),
      .neg   (head.neg_x),
      .dvs   ({1'b0, cfg.cell_width}),
      .quot  (colq)
   );

   rbi_divider u_div_row (
      .clock (clock),
      .adv   (adv),
      .num   (head.num_y),
      .neg   (head.neg_y),
      .dvs   (cfg.height_mag),
      .quot  (rowq)
   );

   assign col_in   = axis_pick(s1_colq_ff, cfg.ncols);
   assign row_in   = axis_pick(s1_rowq_ff, cfg.nrows);
   assign base0_in = s2_row_ff.lo * cfg.ncols;
   assign base1_in = s2_row_ff.hi * cfg.ncols;

   always_comb begin
      if (s2_cmd_ff == rbi_pkg::CMD_WRITE) begin
         for (int k = 0; k < 4; k++) begin
            addr_in[k] = s2_index_ff;
         end
      end else begin
         addr_in[0] = IW'(base0_in + (AW+NDW)'(s2_col_ff.lo));
         addr_in[1] = IW'(base0_in + (AW+NDW)'(s2_col_ff.hi));
         addr_in[2] = IW'(base1_in + (AW+NDW)'(s2_col_ff.lo));
         addr_in[3] = IW'(base1_in + (AW+NDW)'(s2_col_ff.hi));
      end
   end

   always_comb begin
      wl_in   = WT_W'(ONE) - WT_W'(s4_fc_ff);
      p_in[0] = $signed(s4_rd_ff[0]) * $signed({1'b0, wl_in});
      p_in[1] = $signed(s4_rd_ff[1]) * $signed({2'b0, s4_fc_ff});
      p_in[2] = $signed(s4_rd_ff[2]) * $signed({1'b0, wl_in});
      p_in[3] = $signed(s4_rd_ff[3]) * $signed({2'b0, s4_fc_ff});
   end

   // Truncate toward zero, then limit: upper bound first, lower bound last
   always_comb begin
      blend_in = s9_w_ff[2*FB +: VW]
               + VW'(s9_w_ff[W_W-1] && (s9_w_ff[2*FB-1:0] != '0));
      res_in   = s9_inside_ff ? blend_in : s9_v00_ff;
      hi_in    = ($signed(res_in) > $signed(cfg.clamp_max)) ? cfg.clamp_max : res_in;
      if ($signed(hi_in) < $signed(cfg.clamp_min)) begin
         hi_in = cfg.clamp_min;
      end
   end

   assign out_push = adv && s9_valid_ff;
   assign out_pop  = rsp_pop && (out_count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ST; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_query_ff  <= 1'b0;
         s3_we_ff     <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         if (adv) begin
            dv_valid_ff[0] <= head_valid;
            for (int s = 1; s < ST; s++) begin
               dv_valid_ff[s] <= dv_valid_ff[s-1];
            end
            s1_valid_ff <= dv_valid_ff[ST-1];
            s2_valid_ff <= s1_valid_ff;
            s3_query_ff <= s2_valid_ff && (s2_cmd_ff == rbi_pkg::CMD_QUERY);
            s3_we_ff    <= s2_valid_ff && (s2_cmd_ff == rbi_pkg::CMD_WRITE);
            s4_valid_ff <= s3_query_ff;
            s5_valid_ff <= s4_valid_ff;
            s6_valid_ff <= s5_valid_ff;
            s7_valid_ff <= s6_valid_ff;
            s8_valid_ff <= s7_valid_ff;
            s9_valid_ff <= s8_valid_ff;
         end
         if (out_push) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
         out_count_ff <= out_count_ff + 2'(out_push) - 2'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_cmd_ff[0]   <= head.cmd;
         dv_index_ff[0] <= head.index;
         dv_value_ff[0] <= head.value;
         for (int s = 1; s < ST; s++) begin
            dv_cmd_ff[s]   <= dv_cmd_ff[s-1];
            dv_index_ff[s] <= dv_index_ff[s-1];
            dv_value_ff[s] <= dv_value_ff[s-1];
         end

         s1_cmd_ff   <= dv_cmd_ff[ST-1];
         s1_index_ff <= dv_index_ff[ST-1];
         s1_value_ff <= dv_value_ff[ST-1];
         s1_colq_ff  <= colq;
         s1_rowq_ff  <= rowq;

         s2_cmd_ff   <= s1_cmd_ff;
         s2_index_ff <= s1_index_ff;
         s2_value_ff <= s1_value_ff;
         s2_col_ff   <= col_in;
         s2_row_ff   <= row_in;

         s3_value_ff  <= s2_value_ff;
         for (int k = 0; k < 4; k++) begin
            s3_addr_ff[k] <= addr_in[k];
         end
         s3_inside_ff <= s2_col_ff.in_grid && s2_row_ff.in_grid;
         s3_fc_ff     <= s2_col_ff.frac;
         s3_fr_ff     <= s2_row_ff.frac;

         // Every copy takes each write, so all four neighbors are read in the same cycle
         if (s3_we_ff) begin
            store0_mem[s3_addr_ff[0]] <= s3_value_ff;
            store1_mem[s3_addr_ff[1]] <= s3_value_ff;
            store2_mem[s3_addr_ff[2]] <= s3_value_ff;
            store3_mem[s3_addr_ff[3]] <= s3_value_ff;
         end
         s4_rd_ff[0]  <= store0_mem[s3_addr_ff[0]];
         s4_rd_ff[1]  <= store1_mem[s3_addr_ff[1]];
         s4_rd_ff[2]  <= store2_mem[s3_addr_ff[2]];
         s4_rd_ff[3]  <= store3_mem[s3_addr_ff[3]];
         s4_inside_ff <= s3_inside_ff;
         s4_fc_ff     <= s3_fc_ff;
         s4_fr_ff     <= s3_fr_ff;

         for (int k = 0; k < 4; k++) begin
            s5_p_ff[k] <= p_in[k];
         end
         s5_inside_ff <= s4_inside_ff;
         s5_v00_ff    <= s4_rd_ff[0];
         s5_fr_ff     <= s4_fr_ff;

         s6_top_ff    <= s5_p_ff[0] + s5_p_ff[1];
         s6_bot_ff    <= s5_p_ff[2] + s5_p_ff[3];
         s6_inside_ff <= s5_inside_ff;
         s6_v00_ff    <= s5_v00_ff;
         s6_fr_ff     <= s5_fr_ff;

         s7_d_ff      <= s6_bot_ff - s6_top_ff;
         s7_tsh_ff    <= {{(W_W-P_W-FB){s6_top_ff[P_W-1]}}, s6_top_ff, {FB{1'b0}}};
         s7_inside_ff <= s6_inside_ff;
         s7_v00_ff    <= s6_v00_ff;
         s7_fr_ff     <= s6_fr_ff;

         s8_prod_ff   <= s7_d_ff * $signed({1'b0, s7_fr_ff});
         s8_tsh_ff    <= s7_tsh_ff;
         s8_inside_ff <= s7_inside_ff;
         s8_v00_ff    <= s7_v00_ff;

         s9_w_ff      <= s8_tsh_ff + s8_prod_ff;
         s9_inside_ff <= s8_inside_ff;
         s9_v00_ff    <= s8_v00_ff;
      end
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= hi_in;
      end
   end

   assign rsp_empty      = (out_count_ff == 2'd0);
   assign rsp_size_value = out_mem_ff[out_rd_ff];

endmodule

### rtl/raster_bilinear_interpolator.sv
// Raster bilinear interpolator: one write or query accepted per cycle while
// req_full is low. A query result passes through two 49-step pipelined dividers
// and the blend stages into the result queue; writes give no result.
// Reset (synchronous, active high) empties all queues and restores register
// defaults; raster cells hold whatever was last written and need no clearing.
module raster_bilinear_interpolator (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [15:0] req_cell_index,
   input  logic [31:0] req_cell_value,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_size_value,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NDW = rbi_pkg::DIM_W;

   rbi_pkg::cfg_type  cfg_ff;
   rbi_pkg::item_type head;
   logic              head_valid, head_take;
   logic              csr_xfer;
   logic [NDW-1:0]    dim_in;

   // Registers are always writable; a transfer is valid and ready together
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign dim_in    = csr_data[NDW-1:0];

   // Hold derived forms: saturated grid size and height split into
   // magnitude and sign so the divider sees an unsigned divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.cell_width <= rbi_pkg::WIDTH_W'(32'd65536);
         cfg_ff.height_mag <= 32'd65536;
         cfg_ff.height_neg <= 1'b0;
         cfg_ff.ncols      <= NDW'(1);
         cfg_ff.nrows      <= NDW'(1);
         cfg_ff.clamp_min  <= 32'h8000_0000;
         cfg_ff.clamp_max  <= 32'h7FFF_FFFF;
      end else if (csr_xfer) begin
         unique case (rbi_pkg::csr_index_type'(csr_index))
            rbi_pkg::CSR_ORIGIN_X: begin
               cfg_ff.origin_x <= csr_data;
            end
            rbi_pkg::CSR_ORIGIN_Y: begin
               cfg_ff.origin_y <= csr_data;
            end
            rbi_pkg::CSR_CELL_WIDTH: begin
               // drop a zero size, keep the old one
               if (csr_data[rbi_pkg::WIDTH_W-1:0] != '0) begin
                  cfg_ff.cell_width <= csr_data[rbi_pkg::WIDTH_W-1:0];
               end
            end
            rbi_pkg::CSR_CELL_HEIGHT: begin
               if (csr_data != '0) begin
                  cfg_ff.height_neg <= csr_data[31];
                  cfg_ff.height_mag <= csr_data[31] ? (~csr_data + 32'd1) : csr_data;
               end
            end
            rbi_pkg::CSR_COLUMNS: begin
               if (dim_in == '0) begin
                  cfg_ff.ncols <= NDW'(1);
               end else if (dim_in > NDW'(rbi_pkg::MAX_COLS)) begin
                  cfg_ff.ncols <= NDW'(rbi_pkg::MAX_COLS);
               end else begin
                  cfg_ff.ncols <= dim_in;
               end
            end
            rbi_pkg::CSR_ROWS: begin
               if (dim_in == '0) begin
                  cfg_ff.nrows <= NDW'(1);
               end else if (dim_in > NDW'(rbi_pkg::MAX_ROWS)) begin
                  cfg_ff.nrows <= NDW'(rbi_pkg::MAX_ROWS);
               end else begin
                  cfg_ff.nrows <= dim_in;
               end
            end
            rbi_pkg::CSR_CLAMP_MIN: begin
               cfg_ff.clamp_min <= csr_data;
            end
            rbi_pkg::CSR_CLAMP_MAX: begin
               cfg_ff.clamp_max <= csr_data;
            end
         endcase
      end
   end

   // Front: take each transfer, form the dividends, queue the item
   rbi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .head           (head),
      .head_valid     (head_valid),
      .head_take      (head_take)
   );

   // Back: divide, address the raster, blend, limit, queue the result.
   // Writes ride the same pipeline so they land in order with queries.
   rbi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head           (head),
      .head_valid     (head_valid),
      .head_take      (head_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_size_value (rsp_size_value)
   );

endmodule

### tb/raster_bilinear_interpolator_test.sv
module raster_bilinear_interpolator_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the raster and its geometry; predicts the value of each query
   // and holds the predictions in arrival order.
   class raster_scoreboard;
      longint      org_x, org_y, cw, ch, lo_bound, hi_bound;
      int unsigned cols_reg, rows_reg;
      logic [31:0] cells [rbi_pkg::STORE_DEPTH];
      logic [31:0] size_q[$];
      int          errors;

      function new();
         org_x = 0;
         org_y = 0;
         cw = 65536;
         ch = 65536;
         cols_reg = 1;
         rows_reg = 1;
         lo_bound = -64'sd2147483648;
         hi_bound = 64'sd2147483647;
         errors = 0;
      endfunction

      function longint sx(logic [31:0] v);
         return longint'($signed(v));
      endfunction

      function longint floor_div(longint n, longint d);
         longint q, r;
         q = n / d;
         r = n % d;
         if (r != 0 && ((r < 0) != (d < 0)))
            q--;
         return q;
      endfunction

      function longint eff_dim(int unsigned v);
         if (v < 1) return 1;
         if (v > 256) return 256;
         return v;
      endfunction

      function longint cell_at(longint r, longint c, longint nc);
         longint a;
         a = (r * nc + c) & 64'hFFFF;
         return sx(cells[a]);
      endfunction

      function void set_reg(rbi_pkg::csr_index_type i, logic [31:0] d);
         case (i)
            rbi_pkg::CSR_ORIGIN_X:    org_x = sx(d);
            rbi_pkg::CSR_ORIGIN_Y:    org_y = sx(d);
            rbi_pkg::CSR_CELL_WIDTH:  if (d[30:0] != 0) cw = longint'(d[30:0]);
            rbi_pkg::CSR_CELL_HEIGHT: if (d != 0) ch = sx(d);
            rbi_pkg::CSR_COLUMNS:     cols_reg = d[8:0];
            rbi_pkg::CSR_ROWS:        rows_reg = d[8:0];
            rbi_pkg::CSR_CLAMP_MIN:   lo_bound = sx(d);
            rbi_pkg::CSR_CLAMP_MAX:   hi_bound = sx(d);
            default: ;
         endcase
      endfunction

      // Note one accepted transfer: store a write, predict a query.
      function void note_item(rbi_pkg::cmd_type cmd, logic [31:0] px, logic [31:0] py,
                              logic [15:0] idx, logic [31:0] val);
         longint one, nc, nr, colq, rowq, res;
         longint c0, r0, c1, r1, fc, fr, top, bot, th, tl, d, dh, dl, lowq, m, mq;
         bit inexact;
         one = 65536;
         if (cmd == rbi_pkg::CMD_WRITE) begin
            cells[idx] = val;
            return;
         end
         nc = eff_dim(cols_reg);
         nr = eff_dim(rows_reg);
         colq = floor_div((sx(px) - org_x) * one, cw);
         rowq = floor_div((sx(py) - org_y) * one, ch);
         if (colq >= 0 && colq < nc * one && rowq >= 0 && rowq < nr * one) begin
            c0 = colq / one;
            r0 = rowq / one;
            c1 = (c0 + 1 < nc) ? c0 + 1 : nc - 1;
            r1 = (r0 + 1 < nr) ? r0 + 1 : nr - 1;
            fc = colq - c0 * one;
            fr = rowq - r0 * one;
            top = cell_at(r0, c0, nc) * (one - fc) + cell_at(r0, c1, nc) * fc;
            bot = cell_at(r1, c0, nc) * (one - fc) + cell_at(r1, c1, nc) * fc;
            th = floor_div(top, one);
            tl = top - th * one;
            d = bot - top;
            dh = floor_div(d, one);
            dl = d - dh * one;
            lowq = dl * fr;
            m = tl + dh * fr + (lowq >>> 16);
            mq = floor_div(m, one);
            inexact = (m - mq * one) != 0 || (lowq & (one - 1)) != 0;
            res = th + mq;
            // truncate toward zero
            if (res < 0 && inexact)
               res++;
         end else begin
            c0 = floor_div(colq, one);
            r0 = floor_div(rowq, one);
            if (c0 > nc - 1) c0 = nc - 1;
            if (c0 < 0) c0 = 0;
            if (r0 > nr - 1) r0 = nr - 1;
            if (r0 < 0) r0 = 0;
            res = cell_at(r0, c0, nc);
         end
         if (res > hi_bound) res = hi_bound;
         if (res < lo_bound) res = lo_bound;
         size_q = {size_q, res[31:0]};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t size_value %s: got %h want %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_size(logic [31:0] got);
         logic [31:0] want;
         if (size_q.size() == 0) begin
            report("unexpected", got, 'x);
            return;
         end
         want = size_q.pop_front();
         if (got !== want)
            report("wrong", got, want);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_command;
   logic [31:0] req_point_x;
   logic [31:0] req_point_y;
   logic [15:0] req_cell_index;
   logic [31:0] req_cell_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_size_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   raster_bilinear_interpolator uut (.*);

   raster_scoreboard sb = new();

   // Idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
   int  idle_mode = 0;
   bit  hold_rx = 0;
   int  filled = 0;  // cells 0..filled-1 have been written

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Receiver: decide pop on the falling edge, take the result on the rising edge.
   always @(negedge clock) begin
      if (hold_rx)
         rsp_pop <= 1'b0;
      else if (idle_mode == 2)
         rsp_pop <= $urandom_range(99) >= 48;
      else if (idle_mode == 3)
         rsp_pop <= $urandom_range(99) >= 9;
      else
         rsp_pop <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_size(rsp_size_value);
   end

   // Offer one item and hold it until the block takes the transfer.
   task send_item(rbi_pkg::cmd_type cmd, logic [31:0] px, logic [31:0] py,
                  logic [15:0] idx, logic [31:0] val);
      int pct;
      pct = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 9 : 0;
      while ($urandom_range(99) < pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_command    <= cmd;
      req_point_x    <= px;
      req_point_y    <= py;
      req_cell_index <= idx;
      req_cell_value <= val;
      do @(posedge clock); while (req_full);
      sb.note_item(cmd, px, py, idx, val);
      @(negedge clock);
   endtask

   task write_reg(rbi_pkg::csr_index_type i, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= i;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(i, d);
      @(negedge clock);
   endtask

   function logic [31:0] rand_value();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return $urandom_range(0, 1 << 24) - (1 << 23);
      endcase
   endfunction

   // Pick a coordinate along one axis: mostly inside the grid, some on the
   // edges, some beyond, a few anywhere.
   function logic [31:0] rand_coord(longint org, longint step, longint n);
      longint u, p;
      int k;
      k = $urandom_range(9);
      if (k < 7)
         u = $urandom_range(0, n * 65536 - 1);
      else if (k == 7)
         u = ($urandom_range(1) ? n * 65536 : 0) + $urandom_range(0, 6) - 3;
      else if (k == 8)
         u = $urandom_range(1) ? -longint'($urandom_range(1, 300000))
                               : n * 65536 + $urandom_range(0, 300000);
      else
         return $urandom;
      p = org + ((u * step) >>> 16);
      return p[31:0];
   endfunction

   task send_query();
      send_item(rbi_pkg::CMD_QUERY,
                rand_coord(sb.org_x, sb.cw, sb.eff_dim(sb.cols_reg)),
                rand_coord(sb.org_y, sb.ch, sb.eff_dim(sb.rows_reg)),
                $urandom, $urandom);
   endtask

   task drain();
      req_push  <= 1'b0;
      csr_valid <= 1'b0;
      while (sb.size_q.size() != 0)
         @(posedge clock);
      // writes leave no result, so let the pipe empty before touching registers
      repeat (70) @(posedge clock);
      @(negedge clock);
   endtask

   // Program all registers, load any cells the grid now covers, then run a
   // mix of writes and queries.
   task run_phase(logic [31:0] ox, logic [31:0] oy, logic [31:0] w, logic [31:0] h,
                  logic [31:0] nc, logic [31:0] nr, logic [31:0] cmin,
                  logic [31:0] cmax, int n, int mode);
      int needed;
      write_reg(rbi_pkg::CSR_ORIGIN_X, ox);
      write_reg(rbi_pkg::CSR_ORIGIN_Y, oy);
      write_reg(rbi_pkg::CSR_CELL_WIDTH, w);
      write_reg(rbi_pkg::CSR_CELL_HEIGHT, h);
      write_reg(rbi_pkg::CSR_COLUMNS, nc);
      write_reg(rbi_pkg::CSR_ROWS, nr);
      write_reg(rbi_pkg::CSR_CLAMP_MIN, cmin);
      write_reg(rbi_pkg::CSR_CLAMP_MAX, cmax);
      csr_valid <= 1'b0;
      idle_mode = mode;
      needed = sb.eff_dim(sb.cols_reg) * sb.eff_dim(sb.rows_reg);
      while (filled < needed) begin
         send_item(rbi_pkg::CMD_WRITE, 0, 0, filled[15:0], rand_value());
         filled++;
      end
      repeat (n) begin
         if ($urandom_range(3) == 0)
            send_item(rbi_pkg::CMD_WRITE, $urandom, $urandom,
                      $urandom_range(7) == 0 ? $urandom : $urandom_range(0, needed - 1),
                      rand_value());
         else
            send_query();
      end
      drain();
   endtask

   initial begin
      #3_000_000;
      $display("raster_bilinear_interpolator: mismatch");
      $finish;
   end

   initial begin
      int nc, nr;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_command    = rbi_pkg::CMD_WRITE;
      req_point_x    = '0;
      req_point_y    = '0;
      req_cell_index = '0;
      req_cell_value = '0;
      rsp_pop        = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = rbi_pkg::CSR_ORIGIN_X;
      csr_data       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset geometry, one cell, extreme points and values
      send_item(rbi_pkg::CMD_WRITE, 0, 0, 16'h0000, 32'h7FFF_FFFF);
      filled = 1;
      send_item(rbi_pkg::CMD_QUERY, 32'h0000_0000, 32'h0000_0000, 0, 0);
      send_item(rbi_pkg::CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(rbi_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_item(rbi_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000);
      send_item(rbi_pkg::CMD_WRITE, 0, 0, 16'h0000, 32'h8000_0000);
      send_item(rbi_pkg::CMD_QUERY, 32'h0000_8000, 32'h0000_FFFF, 0, 0);
      send_item(rbi_pkg::CMD_WRITE, 0, 0, 16'h0000, 32'hFFFF_FFFF);
      send_item(rbi_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h0001_0000, 0, 0);
      drain();

      // Plain 16x16 grid, no idling
      run_phase(0, 0, 32'h0001_0000, 32'h0001_0000, 16, 16,
                32'h8000_0000, 32'h7FFF_FFFF, 60, 0);

      // One wide row, narrowest cells, north-up, receiver held off to fill the block
      fork
         begin
            @(posedge clock);
            hold_rx = 1;
            repeat (400) @(posedge clock);
            hold_rx = 0;
         end
      join_none
      run_phase(32'hFC17_8000, 32'h0010_0000, 32'h0000_0001, 32'hFFFF_0000, 256, 1,
                32'hFFF0_0000, 32'h0010_0000, 110, 1);

      // One tall column, widest cells, most negative height, crossed bounds
      run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 511,
                32'h0001_0000, 32'hFFFF_0000, 60, 2);

      // Zero sizes are ignored; zero columns act as one
      run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, 5,
                32'h8000_0000, 32'h7FFF_FFFF, 60, 3);

      // Random geometries cycling through the idling modes
      for (int p = 0; p < 6; p++) begin
         nc = $urandom_range(1, 32);
         nr = $urandom_range(1, 256 / nc);
         run_phase($urandom, $urandom,
                   $urandom_range(1) ? $urandom_range(1, 1 << 20) : $urandom,
                   ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1, 1 << 20)),
                   nc, nr,
                   $urandom_range(2) == 0 ? $urandom : 32'h8000_0000,
                   $urandom_range(2) == 0 ? $urandom : 32'h7FFF_FFFF,
                   40, p % 4);
      end

      if (sb.errors == 0)
         $display("raster_bilinear_interpolator: match");
      else
         $display("raster_bilinear_interpolator: mismatch");
      $finish;
   end

endmodule
